>>> design/positional_insert_delete_list_macros.svh
// Assertion macros shared by the list design.
// PIDL_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// PIDL_ASSERT_NEXT checks it in the cycle after the antecedent.
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PIDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_insert_delete_list: assertion failed");

`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional_insert_delete_list: assertion failed");

`else

`define PIDL_ASSERT_NOW(label, clk, rst, ante, cons)

`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/pidl_pkg.sv
package pidl_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int CNT_W  = 7;
   localparam int TYPE_W = 2;
   localparam int STAT_W = 2;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_DELETE = 2'd2,
      REQ_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic              load;
      logic              shift_up;
      logic              shift_down;
      logic [POS_W-1:0]  idx;
      logic [DATA_W-1:0] value;
   } cmd_type;

endpackage

>>> design/pidl_req_if.sv
interface pidl_req_if import pidl_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [TYPE_W-1:0]        req_type;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink (input valid, input req_type, input position, input value,
                 output ready);
endinterface

>>> design/pidl_rsp_if.sv
interface pidl_rsp_if import pidl_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [CNT_W-1:0]         count;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, output status, output count, output read_value,
                   input ready);
   modport sink (input valid, input status, input count, input read_value,
                 output ready);
endinterface

>>> design/positional_insert_delete_list.sv
// Channel  Dir  Handshake          Payload
// req_ch   in   valid / ready      req_type, position, value
// rsp_ch   out  valid / ready      status, count, read_value
//
// Insert, append and delete requests, rejected ones included, answer in the next cycle:
// the whole row of cells shifts in parallel, so such a beat can be taken every cycle
// while req_ready is high. A read, good or bad, passes the registered two-level select
// tree over the cells, then the read value register; no request is taken mid-read.
// Reset clears the entry count and the handshake state; entries are not cleared.
// A result waiting with rsp_ready low holds and keeps req_ready low.
`include "positional_insert_delete_list_macros.svh"

module positional_insert_delete_list import pidl_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic         clock,
   input logic         reset,
   pidl_req_if.sink    req_ch,
   pidl_rsp_if.source  rsp_ch
);

   localparam int GROUP  = 8;
   localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
   localparam int NPAD   = NGROUP * GROUP;

   cmd_type           cmd;
   logic              accept;
   logic              is_read;
   logic              hit;
   status_type        status;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              out_valid_ff;
   logic              read_pend_ff;
   logic              hit_ff;
   logic [STAT_W-1:0] status_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [DATA_W-1:0] read_value_ff;
   logic [DATA_W-1:0] tree_or;
   logic [POS_W:0]    pos_ext;
   logic [POS_W:0]    cnt_ext;
   logic              pos_zero;
   logic              full;

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] sel_pad   [NPAD];
   logic [DATA_W-1:0] grp_or    [NGROUP];
   logic [DATA_W-1:0] grp_ff    [NGROUP];

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !read_pend_ff && (!out_valid_ff || rsp_ch.ready);

   assign pos_ext  = {1'b0, req_ch.position};
   assign cnt_ext  = {1'b0, count_ff};
   assign pos_zero = (req_ch.position == '0);
   assign full     = (count_ff == CNT_W'(CAPACITY));

   // Decode the request and build the command for the row
   always_comb begin
      cmd.load       = 1'b0;
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.idx        = req_ch.position - POS_W'(1);
      cmd.value      = req_ch.value;
      status         = ST_OK;
      count_in       = count_ff;
      is_read        = 1'b0;
      hit            = 1'b0;
      case (req_kind_type'(req_ch.req_type))
         REQ_INSERT: begin
            if (pos_zero || (pos_ext > cnt_ext + (POS_W+1)'(1))) begin
               status = ST_BADPOS;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.load     = accept;
               cmd.shift_up = accept;
               count_in     = accept ? count_ff + CNT_W'(1) : count_ff;
            end
         end
         REQ_APPEND: begin
            cmd.idx = count_ff;
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.load = accept;
               count_in = accept ? count_ff + CNT_W'(1) : count_ff;
            end
         end
         REQ_DELETE: begin
            if (pos_zero || (pos_ext > cnt_ext)) begin
               status = ST_BADPOS;
            end else begin
               cmd.shift_down = accept;
               count_in       = accept ? count_ff - CNT_W'(1) : count_ff;
            end
         end
         REQ_READ: begin
            is_read = 1'b1;
            if (pos_zero || (pos_ext > cnt_ext)) begin
               status = ST_BADPOS;
            end else begin
               hit = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // Row of cells; pad the select outputs up to whole groups
   for (genvar i = 0; i < NPAD; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
         logic [DATA_W-1:0] left_d;
         logic [DATA_W-1:0] right_d;
         logic [DATA_W-1:0] sel_d;

         if (i == 0) begin : g_first
            assign left_d = cell_data[i];
         end else begin : g_mid_l
            assign left_d = cell_data[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
         end else begin : g_mid_r
            assign right_d = cell_data[i+1];
         end

         pidl_cell #(.INDEX(i)) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .sel_data   (sel_d)
         );
         assign sel_pad[i] = sel_d;
      end else begin : g_pad
         assign sel_pad[i] = '0;
      end
   end

   // First tree level: merge each group of cells and register
   for (genvar g = 0; g < NGROUP; g++) begin : g_grp
      always_comb begin
         grp_or[g] = '0;
         for (int k = 0; k < GROUP; k++) begin
            grp_or[g] = grp_or[g] | sel_pad[g*GROUP + k];
         end
      end

      always_ff @(posedge clock) begin
         grp_ff[g] <= grp_or[g];
      end
   end

   // Second tree level: merge the group registers
   always_comb begin
      tree_or = '0;
      for (int g = 0; g < NGROUP; g++) begin
         tree_or = tree_or | grp_ff[g];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         read_pend_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         read_pend_ff <= accept && is_read;
         if (accept && !is_read) begin
            out_valid_ff <= 1'b1;
         end else if (read_pend_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on accept, fill the read value in the cycle after a read is accepted
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status;
         rsp_count_ff  <= count_in;
         read_value_ff <= '0;
         hit_ff        <= hit;
      end else if (read_pend_ff) begin
         read_value_ff <= hit_ff ? tree_or : '0;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.read_value = read_value_ff;

   `PIDL_ASSERT_NEXT(a_read_pends, clock, reset, accept && is_read, read_pend_ff)
   `PIDL_ASSERT_NEXT(a_pend_shows, clock, reset, read_pend_ff, out_valid_ff)
   `PIDL_ASSERT_NOW(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `PIDL_ASSERT_NEXT(a_count_hold, clock, reset, !accept, $stable(count_ff))

endmodule

>>> design/pidl_cell.sv
module pidl_cell import pidl_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  cmd_type           cmd,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data,
   output logic [DATA_W-1:0] sel_data
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Pick the new entry: load at the target, take the left neighbor above it
   // on insert, take the right neighbor from the target up on delete
   always_comb begin
      data_in = data_ff;
      if (cmd.load && (cmd.idx == MY_IDX)) begin
         data_in = cmd.value;
      end else if (cmd.shift_up && (cmd.idx < MY_IDX)) begin
         data_in = left_data;
      end else if (cmd.shift_down && (cmd.idx <= MY_IDX)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

   // Offer the entry to the read tree only when this cell is addressed
   assign sel_data = (cmd.idx == MY_IDX) ? data_ff : '0;

endmodule
